// File: hdl/agce_pkg.sv
// Shared types, codes and constants of the antenna gain correction engine.
package agce_pkg;

	localparam int ANTENNAS_DEF = 32;
	localparam int SLOTS_DEF = 1024;

	localparam logic [23:0] UNITY_GAIN = 24'h01_0000;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
	localparam logic [23:0] MAX24 = 24'hFF_FFFF;

	localparam int STEP_W = 6;
	localparam logic [STEP_W-1:0] MUL_STEPS = 6'd48;
	localparam logic [STEP_W-1:0] DIV_STEPS = 6'd32;

	localparam logic REG_FIRST_MASK = 1'b0;

	typedef enum logic [2:0] {
		OP_APPLY  = 3'd0,
		OP_UNDO   = 3'd1,
		OP_ADJUST = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_BAD    = 3'd4
	} op_t;

	typedef struct packed {
		logic        bad;
		logic [15:0] phase;
		logic [23:0] gain;
	} entry_t;

	localparam entry_t NEUTRAL = '{bad: 1'b0, phase: 16'h0000, gain: UNITY_GAIN};

endpackage

// File: hdl/agce_ram.sv
// Generic single-port synchronous RAM with registered read.
module agce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: hdl/antenna_gain_correction_engine.sv
// Top level: per-antenna gain/phase correction table and its arithmetic sequencer.
//
//  channel | direction | handshake           | word
//  in      | input     | in_valid / in_stall | op, slot, antennas, visibility, edit fields
//  out     | output    | out_valid/out_stall | corrected visibility and saturated mark
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (flag masks)
//
// Edits (ops 2 to 4) and unused codes hold in_stall through the table reads and the write
// state. Apply and undo with a zero gain product or undo without bit0 skip the arithmetic
// and go straight to the result; otherwise a 48-step shift-add multiplier runs twice and a
// 32-step restoring divider once, all working on one 128-bit accumulator.
// After reset every table entry is swept to unity with in_stall high.
// A result waits in the output register under out_stall while the next word is taken; a
// second finished result holds in_stall high until the output register frees.
module antenna_gain_correction_engine #(
	parameter int ANTENNAS = agce_pkg::ANTENNAS_DEF,
	parameter int SLOTS = agce_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic [9:0]         slot,
	input  logic [4:0]         antenna_first,
	input  logic [4:0]         antenna_second,
	input  logic [31:0]        amplitude,
	input  logic signed [15:0] phase,
	input  logic [31:0]        weight,
	input  logic [7:0]         flags,
	input  logic [2:0]         undo_mask,
	input  logic [23:0]        gain_factor,
	input  logic signed [15:0] phase_offset,
	input  logic               bad_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        out_amplitude,
	output logic signed [15:0] out_phase,
	output logic [31:0]        out_weight,
	output logic [7:0]         out_flags,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data
);

	localparam int DEPTH = SLOTS * ANTENNAS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b00_0000_0001,
		ST_IDLE  = 10'b00_0000_0010,
		ST_RDA   = 10'b00_0000_0100,
		ST_RDB   = 10'b00_0000_1000,
		ST_WR    = 10'b00_0001_0000,
		ST_GMUL  = 10'b00_0010_0000,
		ST_SQR   = 10'b00_0100_0000,
		ST_MUL   = 10'b00_1000_0000,
		ST_DIV   = 10'b01_0000_0000,
		ST_DONE  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [agce_pkg::STEP_W-1:0] cnt_q;
	logic out_valid_q;
	logic [7:0] ffm_q, fsm_q;

	// captured word
	logic [2:0] op_q;
	logic [9:0] slot_q;
	logic [4:0] ta_q, tb_q;
	logic [31:0] amp_q, wt_q;
	logic [15:0] phase_q, poff_q;
	logic [7:0] flags_q;
	logic [2:0] mask_q;
	logic [23:0] factor_q;
	logic badv_q;

	agce_pkg::entry_t ea_q, eb, wr_entry, ram_wdata, ram_rdata;
	logic [47:0] g_q, mb_q;
	logic [95:0] g2_q;
	logic [127:0] ma_q, acc_q;
	logic [31:0] quo_q;
	logic dsat_q;
	logic [31:0] res_amp_q, res_wt_q;
	logic [15:0] res_phase_q;
	logic [7:0] res_flags_q;
	logic res_sat_q;
	logic [31:0] out_amp_q, out_wt_q;
	logic [15:0] out_phase_q;
	logic [7:0] out_flags_q;
	logic out_sat_q;

	logic [31:0] idx_a, idx_b;
	logic va, vb, is_apply, is_res, is_edit, math, out_free, div_ge;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0] dp;
	logic [23:0] fac;
	logic [47:0] adj;
	logic [127:0] div_num, div_den;
	logic [31:0] quo_n;

	assign idx_a = 32'(slot_q) * 32'(ANTENNAS) + 32'(ta_q);
	assign idx_b = 32'(slot_q) * 32'(ANTENNAS) + 32'(tb_q);
	assign va = (32'(slot_q) < 32'(SLOTS)) && (32'(ta_q) < 32'(ANTENNAS));
	assign vb = (32'(slot_q) < 32'(SLOTS)) && (32'(tb_q) < 32'(ANTENNAS));

	assign is_apply = (op_q == agce_pkg::OP_APPLY);
	assign is_res = is_apply || (op_q == agce_pkg::OP_UNDO);
	assign is_edit = (op_q == agce_pkg::OP_ADJUST) || (op_q == agce_pkg::OP_CLEAR)
		|| (op_q == agce_pkg::OP_BAD);
	assign math = (g_q != 48'd0) && (is_apply || mask_q[0]);
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// entry b arrives from the RAM during the gain product cycle
	assign eb = vb ? ram_rdata : agce_pkg::NEUTRAL;
	assign dp = ea_q.phase - eb.phase;

	// table edit
	assign fac = (factor_q == 24'd0) ? agce_pkg::UNITY_GAIN : factor_q;
	assign adj = {24'd0, ea_q.gain} * {24'd0, fac};

	always_comb begin
		wr_entry = ea_q;
		unique case (op_q)
			agce_pkg::OP_ADJUST: begin
				wr_entry.gain = (adj[47:40] != 8'd0) ? agce_pkg::MAX24 : adj[39:16];
				wr_entry.phase = ea_q.phase + poff_q;
			end
			agce_pkg::OP_CLEAR: begin
				wr_entry.gain = agce_pkg::UNITY_GAIN;
				wr_entry.phase = 16'd0;
			end
			agce_pkg::OP_BAD: wr_entry.bad = badv_q;
			default: wr_entry = ea_q;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = idx_a[AW-1:0];
		ram_wdata = wr_entry;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
				ram_wdata = agce_pkg::NEUTRAL;
			end
			ST_RDB: ram_addr = idx_b[AW-1:0];
			ST_WR: ram_we = va && is_edit;
			default: ram_we = 1'b0;
		endcase
	end

	agce_ram #(
		.WIDTH($bits(agce_pkg::entry_t)),
		.DEPTH(DEPTH)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// divider operands: apply divides weight*2^64 by g^2, undo divides amplitude*2^32 by g
	assign div_num = is_apply ? {32'd0, wt_q, 64'd0} : {64'd0, amp_q, 32'd0};
	assign div_den = is_apply ? {32'd0, g2_q} : {80'd0, g_q};
	assign div_ge = (acc_q >= ma_q);
	assign quo_n = {quo_q[30:0], div_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			ffm_q <= 8'd1;
			fsm_q <= 8'd2;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == agce_pkg::REG_FIRST_MASK) begin
					ffm_q <= cfg_data;
				end else begin
					fsm_q <= cfg_data;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: if (in_valid) begin
					state_q <= ST_RDA;
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= is_res ? ST_GMUL : ST_WR;
				ST_WR: state_q <= ST_IDLE;
				ST_GMUL: begin
					cnt_q <= '0;
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					if (cnt_q == '0 && !math) begin
						state_q <= ST_DONE;
					end else if (cnt_q == agce_pkg::MUL_STEPS) begin
						cnt_q <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (cnt_q == agce_pkg::MUL_STEPS) begin
						cnt_q <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == agce_pkg::DIV_STEPS) begin
						cnt_q <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: if (out_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				op_q <= op;
				slot_q <= slot;
				ta_q <= antenna_first;
				tb_q <= antenna_second;
				amp_q <= amplitude;
				phase_q <= phase;
				wt_q <= weight;
				flags_q <= flags;
				mask_q <= undo_mask;
				factor_q <= gain_factor;
				poff_q <= phase_offset;
				badv_q <= bad_value;
			end
			ST_RDB: ea_q <= va ? ram_rdata : agce_pkg::NEUTRAL;
			ST_GMUL: begin
				g_q <= {24'd0, ea_q.gain} * {24'd0, eb.gain};
				res_amp_q <= amp_q;
				res_wt_q <= wt_q;
				res_sat_q <= 1'b0;
				if (is_apply) begin
					res_phase_q <= phase_q + dp;
					res_flags_q <= flags_q | (ea_q.bad ? ffm_q : 8'd0)
						| (eb.bad ? fsm_q : 8'd0);
				end else begin
					res_phase_q <= mask_q[1] ? phase_q - dp : phase_q;
					res_flags_q <= mask_q[2] ? flags_q & ~(ffm_q | fsm_q) : flags_q;
				end
			end
			ST_SQR, ST_MUL: begin
				if (cnt_q == '0) begin
					acc_q <= '0;
					if (state_q == ST_SQR) begin
						ma_q <= {80'd0, g_q};
						mb_q <= g_q;
					end else begin
						// acc holds g^2 from the squaring pass
						g2_q <= acc_q[95:0];
						ma_q <= is_apply ? {80'd0, g_q} : acc_q;
						mb_q <= is_apply ? {16'd0, amp_q} : {16'd0, wt_q};
					end
				end else begin
					if (mb_q[0]) begin
						acc_q <= acc_q + ma_q;
					end
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					// take the second product, then load the divider
					if (is_apply) begin
						res_amp_q <= (acc_q[127:64] != 64'd0) ? agce_pkg::MAX32 : acc_q[63:32];
						res_sat_q <= res_sat_q | (acc_q[127:64] != 64'd0);
					end else begin
						res_wt_q <= (acc_q[127:96] != 32'd0) ? agce_pkg::MAX32 : acc_q[95:64];
						res_sat_q <= res_sat_q | (acc_q[127:96] != 32'd0);
					end
					acc_q <= div_num;
					ma_q <= div_den << 31;
					quo_q <= '0;
					dsat_q <= (div_num >= (div_den << 32));
				end else begin
					if (div_ge) begin
						acc_q <= acc_q - ma_q;
					end
					quo_q <= quo_n;
					ma_q <= ma_q >> 1;
					if (cnt_q == agce_pkg::DIV_STEPS) begin
						res_sat_q <= res_sat_q | dsat_q;
						if (is_apply) begin
							res_wt_q <= dsat_q ? agce_pkg::MAX32 : quo_n;
						end else begin
							res_amp_q <= dsat_q ? agce_pkg::MAX32 : quo_n;
						end
					end
				end
			end
			ST_DONE: if (out_free) begin
				out_amp_q <= res_amp_q;
				out_phase_q <= res_phase_q;
				out_wt_q <= res_wt_q;
				out_flags_q <= res_flags_q;
				out_sat_q <= res_sat_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_amplitude = out_amp_q;
	assign out_phase = $signed(out_phase_q);
	assign out_weight = out_wt_q;
	assign out_flags = out_flags_q;
	assign saturated = out_sat_q;

`ifndef SYNTHESIS
	a_ram_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_WR))
		else $error("table written outside clear pass or edit");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_RDA)
		else $error("accepted word did not start a table read");

	a_done_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> (op_q == agce_pkg::OP_APPLY || op_q == agce_pkg::OP_UNDO))
		else $error("result produced for an edit op");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= agce_pkg::DIV_STEPS)
		else $error("divider step count overran");
`endif

endmodule
